// ----- sv/sdf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdf_pkg
// Shared constants, codes, types and helpers of the segment distance field.
// ----------------------------------------------------------------------------
package sdf_pkg;

  localparam int MAX_COLUMNS_DEF   = 512;
  localparam int MAX_ROWS_DEF      = 512;
  localparam int FRACTION_BITS_DEF = 4;

  localparam int BOX_MARGIN  = 10;
  localparam int RING2_SCALE = 2;
  localparam int RING3_SCALE = 8;
  localparam int RING1_STEP  = 1;
  localparam int RING2_STEP  = 2;
  localparam int RING3_STEP  = 5;

  // operation codes
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_SEG   = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // register indexes
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_CLEAR  = 2'd2;
  localparam logic [1:0] REG_RADIUS = 2'd3;

  // walk phases
  localparam logic [1:0] PH_BOX   = 2'd0;
  localparam logic [1:0] PH_RING1 = 2'd1;
  localparam logic [1:0] PH_RING2 = 2'd2;
  localparam logic [1:0] PH_RING3 = 2'd3;

  // one cell offset relative to both segment endpoints
  typedef struct packed {
    logic signed [12:0] px;
    logic signed [12:0] py;
    logic signed [12:0] qx;
    logic signed [12:0] qy;
  } dist_req_t;

  function automatic logic [31:0] sat32(input logic [63:0] v);
    sat32 = (v > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

endpackage

// ----- sv/segment_distance_field_update.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_distance_field_update
// Grid of squared distances with clear, read and add-segment operations.
// ----------------------------------------------------------------------------
// Usage: present an operation and its fields with start high; it is taken at
// a clock edge where busy is low. Exactly one result beat follows, marked by
// done for one cycle; cell_value and read_inside hold the read result (zero
// for clear and add segment). The receiver cannot stall, so sample on done.
// Configuration is written through cfg_write/cfg_index/cfg_data while idle.
// Clear writes the grid, one grid write a cycle. A read outside the grid is
// answered without a grid access. Add segment walks the bounding box,
// clipped to the grid, then the rings in full; an endpoint-nearest cell
// takes its distance from the multiplies, any other cell needs the divider.
// The divider and the grid memory set the rate: one cell is in flight
// at a time, so its read-compare-write completes before the next read.
// After reset the grid contents are undefined until the first clear; the
// registers take their reset values at once.
// ----------------------------------------------------------------------------
module segment_distance_field_update #(
  parameter int MAX_COLUMNS   = sdf_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS      = sdf_pkg::MAX_ROWS_DEF,
  parameter int FRACTION_BITS = sdf_pkg::FRACTION_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         operation,
  input  logic signed [11:0] start_x,
  input  logic signed [11:0] start_y,
  input  logic signed [11:0] end_x,
  input  logic signed [11:0] end_y,
  input  logic signed [11:0] read_x,
  input  logic signed [11:0] read_y,
  output logic               done,
  output logic [31:0]        cell_value,
  output logic               read_inside,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import sdf_pkg::*;

  localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b00000001,
    S_CLEAR  = 8'b00000010,
    S_RDWAIT = 8'b00000100,
    S_SEG0   = 8'b00001000,
    S_SEG1   = 8'b00010000,
    S_PHASE  = 8'b00100000,
    S_WALK   = 8'b01000000,
    S_CELL   = 8'b10000000
  } state_t;

  state_t state;

  // configuration
  logic [9:0]  field_width, field_height;
  logic [31:0] clear_value;
  logic [6:0]  ring_radius;

  // segment
  logic signed [13:0] ax, ay, bx, by;
  logic signed [12:0] dx, dy;
  logic signed [26:0] sq_a, sq_b;
  logic [24:0]        len2;

  // walker
  logic [1:0]         phase;
  logic signed [13:0] cx, cy, x_hi, y_lo, y_hi, lo;
  logic [2:0]         step;
  logic [AW-1:0]      clr_addr, cell_addr;

  // grid port
  logic          mem_wr, mem_rd;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [31:0]   mem_wdata, mem_rdata;

  // distance unit
  logic       dist_start, dist_done;
  dist_req_t  dist_req;
  logic [31:0] cell_dist;

  // derived
  logic signed [13:0] effw, effh, rx, ry, ox, oy, r14;
  logic signed [13:0] xmin, xmax, ymin, ymax, b_xlo, b_xhi, b_ylo, b_yhi;
  logic               cell_in, read_in, cell_ok;
  logic [AW-1:0]      walk_addr, read_addr;

  always_comb begin
    effw = (field_width > 10'(MAX_COLUMNS)) ? 14'(MAX_COLUMNS) : 14'(field_width);
    effh = (field_height > 10'(MAX_ROWS)) ? 14'(MAX_ROWS) : 14'(field_height);
    rx   = 14'(read_x);
    ry   = 14'(read_y);
    r14  = 14'(ring_radius);

    xmin  = (ax < bx) ? ax : bx;
    xmax  = (ax > bx) ? ax : bx;
    ymin  = (ay < by) ? ay : by;
    ymax  = (ay > by) ? ay : by;
    b_xlo = xmin - 14'(BOX_MARGIN);
    b_xhi = xmax + 14'(BOX_MARGIN);
    b_ylo = ymin - 14'(BOX_MARGIN);
    b_yhi = ymax + 14'(BOX_MARGIN);
    if (b_xlo < 0) b_xlo = '0;
    if (b_xhi > effw - 14'sd1) b_xhi = effw - 14'sd1;
    if (b_ylo < 0) b_ylo = '0;
    if (b_yhi > effh) b_yhi = effh;

    ox      = cx - ax;
    oy      = cy - ay;
    if (ox < 0) ox = -ox;
    if (oy < 0) oy = -oy;
    cell_in = (cx >= 0) && (cx < effw) && (cy >= 0) && (cy < effh);
    cell_ok = cell_in && (ox >= lo) && (oy >= lo);
    read_in = (rx >= 0) && (rx < effw) && (ry >= 0) && (ry < effh);

    walk_addr = AW'(AW'(cy[12:0]) * AW'(MAX_COLUMNS)) + AW'(cx[12:0]);
    read_addr = AW'(AW'(ry[12:0]) * AW'(MAX_COLUMNS)) + AW'(rx[12:0]);

    dist_req.px = 13'(cx - ax);
    dist_req.py = 13'(cy - ay);
    dist_req.qx = 13'(cx - bx);
    dist_req.qy = 13'(cy - by);
  end

  assign busy = (state != S_IDLE);

  // grid port steering
  always_comb begin
    mem_wr     = 1'b0;
    mem_waddr  = cell_addr;
    mem_wdata  = cell_dist;
    mem_rd     = 1'b0;
    mem_raddr  = walk_addr;
    dist_start = 1'b0;
    if (state == S_CLEAR) begin
      mem_wr    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = clear_value;
    end
    if (state == S_CELL && dist_done && cell_dist < mem_rdata) begin
      mem_wr = 1'b1;
    end
    if (state == S_IDLE && start && operation == OP_READ && read_in) begin
      mem_rd    = 1'b1;
      mem_raddr = read_addr;
    end
    if (state == S_WALK && cx <= x_hi && cy < y_hi && cell_ok) begin
      mem_rd     = 1'b1;
      dist_start = 1'b1;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      field_width  <= 10'd512;
      field_height <= 10'd512;
      clear_value  <= 32'hFFFF_FFFF;
      ring_radius  <= 7'd4;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_WIDTH:  field_width  <= cfg_data[9:0];
        REG_HEIGHT: field_height <= cfg_data[9:0];
        REG_CLEAR:  clear_value  <= cfg_data;
        REG_RADIUS: ring_radius  <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // operation sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            cell_value  <= '0;
            read_inside <= 1'b0;
            ax <= 14'(start_x);
            ay <= 14'(start_y);
            bx <= 14'(end_x);
            by <= 14'(end_y);
            dx <= 13'(end_x) - 13'(start_x);
            dy <= 13'(end_y) - 13'(start_y);
            case (operation)
              OP_CLEAR: begin
                clr_addr <= '0;
                state    <= S_CLEAR;
              end
              OP_SEG: state <= S_SEG0;
              OP_READ: begin
                if (read_in) begin
                  state <= S_RDWAIT;
                end else begin
                  cell_value <= clear_value;
                  done       <= 1'b1;
                end
              end
              default: done <= 1'b1;
            endcase
          end
        end
        S_CLEAR: begin
          // sweep every entry, one write a cycle
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(DEPTH - 1)) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_RDWAIT: begin
          cell_value  <= mem_rdata;
          read_inside <= 1'b1;
          done        <= 1'b1;
          state       <= S_IDLE;
        end
        S_SEG0: begin
          sq_a  <= 27'(dx) * 27'(dx);
          sq_b  <= 27'(dy) * 27'(dy);
          state <= S_SEG1;
        end
        S_SEG1: begin
          len2  <= sq_a[24:0] + sq_b[24:0];
          phase <= PH_BOX;
          state <= S_PHASE;
        end
        S_PHASE: begin
          // load the bounds of the next walk
          unique case (phase)
            PH_BOX: begin
              cx <= b_xlo; x_hi <= b_xhi; y_lo <= b_ylo; y_hi <= b_yhi;
              cy <= b_ylo; lo <= '0; step <= 3'(RING1_STEP);
            end
            PH_RING1: begin
              cx <= ax - r14; x_hi <= ax + r14;
              y_lo <= ay - r14; cy <= ay - r14; y_hi <= ay + r14;
              lo <= '0; step <= 3'(RING1_STEP);
            end
            PH_RING2: begin
              cx <= ax - 14'(r14 * RING2_SCALE); x_hi <= ax + 14'(r14 * RING2_SCALE);
              y_lo <= ay - 14'(r14 * RING2_SCALE); cy <= ay - 14'(r14 * RING2_SCALE);
              y_hi <= ay + 14'(r14 * RING2_SCALE);
              lo <= r14; step <= 3'(RING2_STEP);
            end
            PH_RING3: begin
              cx <= ax - 14'(r14 * RING3_SCALE); x_hi <= ax + 14'(r14 * RING3_SCALE);
              y_lo <= ay - 14'(r14 * RING3_SCALE); cy <= ay - 14'(r14 * RING3_SCALE);
              y_hi <= ay + 14'(r14 * RING3_SCALE);
              lo <= 14'(r14 * RING2_SCALE); step <= 3'(RING3_STEP);
            end
            default: ;
          endcase
          state <= S_WALK;
        end
        S_WALK: begin
          if (cx > x_hi) begin
            if (phase == PH_RING3) begin
              done  <= 1'b1;
              state <= S_IDLE;
            end else begin
              phase <= phase + 1'b1;
              state <= S_PHASE;
            end
          end else if (cy >= y_hi) begin
            cx <= cx + 14'(step);
            cy <= y_lo;
          end else begin
            cy <= cy + 14'(step);
            if (cell_ok) begin
              cell_addr <= walk_addr;
              state     <= S_CELL;
            end
          end
        end
        S_CELL: begin
          // hold until the distance is ready; write-back, if it is smaller, happens on done
          if (dist_done) begin
            state <= S_WALK;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  sdf_grid_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_rd),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  sdf_dist #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dist (
    .clk      (clk),
    .rst      (rst),
    .start    (dist_start),
    .req      (dist_req),
    .dx       (dx),
    .dy       (dy),
    .len2     (len2),
    .done     (dist_done),
    .dist_val (cell_dist)
  );

endmodule

// ----- sv/sdf_grid_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdf_grid_mem
// Distance grid store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sdf_grid_mem #(
  parameter int DEPTH = 262144,
  parameter int AW    = 18
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [31:0]   wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [31:0]   rd_data
);

  logic [31:0] cells [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      cells[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= cells[rd_addr];
    end
  end

endmodule

// ----- sv/sdf_dist.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdf_dist
// Squared point-to-segment distance, one multiply pair per cycle and a
// one-bit-per-cycle restoring divider for the perpendicular case.
// ----------------------------------------------------------------------------
module sdf_dist #(
  parameter int FRACTION_BITS = sdf_pkg::FRACTION_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  sdf_pkg::dist_req_t  req,
  input  logic signed [12:0]  dx,
  input  logic signed [12:0]  dy,
  input  logic [24:0]         len2,
  output logic                done,
  output logic [31:0]         dist_val
);
  import sdf_pkg::*;

  localparam int QW = 26 + FRACTION_BITS;
  localparam int NW = 51 + FRACTION_BITS;
  localparam int CW = $clog2(QW);

  typedef enum logic [8:0] {
    D_IDLE  = 9'b000000001,
    D_M1    = 9'b000000010,
    D_M2    = 9'b000000100,
    D_M3    = 9'b000001000,
    D_M4    = 9'b000010000,
    D_M5    = 9'b000100000,
    D_SQ    = 9'b001000000,
    D_DINIT = 9'b010000000,
    D_DIV   = 9'b100000000
  } dstate_t;

  dstate_t            state;
  logic signed [12:0] px, py, qx, qy;
  logic signed [26:0] ma, mb, dot;
  logic [25:0]        p2, q2;
  logic [24:0]        ac;
  logic [49:0]        sq;
  logic [24:0]        rem;
  logic [QW-1:0]      numlo;
  logic [QW-1:0]      quo;
  logic [CW-1:0]      cnt;

  logic signed [26:0] cr;
  logic [NW-1:0]      num;
  logic [25:0]        trial;
  logic               ge;

  always_comb begin
    cr    = ma - mb;
    num   = (NW'(sq) << FRACTION_BITS) + NW'(len2 >> 1);
    trial = {rem, numlo[QW-1]};
    ge    = trial >= {1'b0, len2};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        D_IDLE: begin
          if (start) begin
            px    <= req.px;
            py    <= req.py;
            qx    <= req.qx;
            qy    <= req.qy;
            state <= D_M1;
          end
        end
        D_M1: begin
          ma    <= 27'(px) * 27'(dx);
          mb    <= 27'(py) * 27'(dy);
          state <= D_M2;
        end
        D_M2: begin
          dot   <= ma + mb;
          ma    <= 27'(px) * 27'(px);
          mb    <= 27'(py) * 27'(py);
          state <= D_M3;
        end
        D_M3: begin
          p2    <= ma[25:0] + mb[25:0];
          ma    <= 27'(qx) * 27'(qx);
          mb    <= 27'(qy) * 27'(qy);
          state <= D_M4;
        end
        D_M4: begin
          q2    <= ma[25:0] + mb[25:0];
          ma    <= 27'(dx) * 27'(py);
          mb    <= 27'(dy) * 27'(px);
          state <= D_M5;
        end
        D_M5: begin
          if (len2 == '0 || dot[26]) begin
            dist_val <= sat32(64'(p2) << FRACTION_BITS);
            done     <= 1'b1;
            state    <= D_IDLE;
          end else if (dot > $signed({2'b00, len2})) begin
            dist_val <= sat32(64'(q2) << FRACTION_BITS);
            done     <= 1'b1;
            state    <= D_IDLE;
          end else begin
            ac    <= cr[26] ? 25'(-cr) : cr[24:0];
            state <= D_SQ;
          end
        end
        D_SQ: begin
          sq    <= 50'(ac) * 50'(ac);
          state <= D_DINIT;
        end
        D_DINIT: begin
          rem   <= num[NW-1:QW];
          numlo <= num[QW-1:0];
          quo   <= '0;
          cnt   <= CW'(QW - 1);
          state <= D_DIV;
        end
        D_DIV: begin
          rem   <= ge ? 25'(trial - {1'b0, len2}) : trial[24:0];
          quo   <= {quo[QW-2:0], ge};
          numlo <= numlo << 1;
          cnt   <= cnt - 1'b1;
          if (cnt == '0) begin
            dist_val <= sat32(64'({quo[QW-2:0], ge}));
            done     <= 1'b1;
            state    <= D_IDLE;
          end
        end
        default: state <= D_IDLE;
      endcase
    end
  end

endmodule
